// ----- rtl/tsza_pkg.sv -----
// Shared constants, codes and control types of the thermistor zone averager.
package tsza_pkg;

  localparam int CHANNELS = 8;
  localparam int ZONES    = 4;

  localparam int REQ_W     = 1;
  localparam int CH_W      = 3;
  localparam int CODE_W    = 12;
  localparam int TEMP_W    = 13;
  localparam int FAULT_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam int CH_IDX_W = $clog2(CHANNELS);
  localparam int ZONE_W   = (ZONES > 1) ? $clog2(ZONES) : 1;

  // Conversion datapath widths.
  localparam int MANT_W    = 31;
  localparam int FRAC_W    = 28;
  localparam int EXP_W     = 4;
  localparam int LOG_W     = EXP_W + FRAC_W;
  localparam int DQ_W      = 48;
  localparam int DIVISOR_W = 52;
  localparam int DIVIDEND_W = 64;
  localparam int QUO_W     = 14;

  localparam int LOG_STEPS = FRAC_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W     = 5;

  localparam logic [CODE_W-1:0] CODE_FULL      = 12'd4095;
  localparam logic [CODE_W-1:0] LOW_LIMIT_RST  = 12'd10;
  localparam logic [CODE_W-1:0] HIGH_LIMIT_RST = 12'd4085;

  localparam logic [31:0]           LN2_Q32  = 32'd2977044472;
  localparam logic [14:0]           DQ_SLOPE = 15'd29815;
  localparam logic [DQ_W-1:0]       DQ_BASE  = DQ_W'(64'd395000 << 28);
  localparam logic [DIVIDEND_W-1:0] TEN_N    = 64'd18843080000 << 28;
  localparam logic signed [15:0]    Q_OFFSET = 16'sd4370;

  localparam logic signed [TEMP_W-1:0] T_MIN       = -13'sd2032;
  localparam logic signed [TEMP_W-1:0] T_MAX       = 13'sd3200;
  localparam logic signed [TEMP_W-1:0] T_LOW_FAULT  = -13'sd2032;
  localparam logic signed [TEMP_W-1:0] T_HIGH_FAULT = 13'sd3200;
  localparam logic signed [TEMP_W-1:0] ZONE_RST     = 13'sd400;

  localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_LOW  = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_HIGH = 2'd2;

  localparam logic KIND_CHAN = 1'b0;
  localparam logic KIND_ZONE = 1'b1;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_END    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 2'd1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_CHECK = 10'b00_0000_0010,
    S_LOG   = 10'b00_0000_0100,
    S_MAG   = 10'b00_0000_1000,
    S_LN    = 10'b00_0001_0000,
    S_DQ    = 10'b00_0010_0000,
    S_DIVLD = 10'b00_0100_0000,
    S_DIV   = 10'b00_1000_0000,
    S_CHOUT = 10'b01_0000_0000,
    S_ZONE  = 10'b10_0000_0000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              conv_start;
    logic              log_step;
    logic              mag_step;
    logic              ln_step;
    logic              dq_step;
    logic              div_load;
    logic              div_step;
    logic              chan_wr;
    logic              zone_wr;
    logic [ZONE_W-1:0] zone_idx;
    logic              last;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic is_end;
    logic ch_present;
    logic fault_hit;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/tsza_conv.sv -----
// Beta-equation conversion datapath: log2 by squaring, ln scaling, and a restoring divider.
module tsza_conv (
  input  logic                            clk_i,
  input  tsza_pkg::cmd_t                  cmd_i,
  input  logic [tsza_pkg::CODE_W-1:0]     code_i,
  output logic signed [tsza_pkg::TEMP_W-1:0] temp_o
);
  import tsza_pkg::*;

  logic [MANT_W-1:0]    ma_q, mb_q, ma_d, mb_d;
  logic [EXP_W-1:0]     ka_q, kb_q;
  logic [FRAC_W-1:0]    fa_q, fb_q;
  logic                 neg_q;
  logic [LOG_W-1:0]     mag_q;
  logic [31:0]          lnmag_q;
  logic [DQ_W-1:0]      dq_q;
  logic [DIVISOR_W-1:0] div_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [QUO_W-1:0]     low_q;
  logic [QUO_W-1:0]     quo_q;

  logic [CODE_W-1:0]     code_b;
  logic [EXP_W-1:0]      ka_d, kb_d;
  logic [MANT_W-1:0]     ma_init, mb_init;
  logic [2*MANT_W-1:0]   sq_a, sq_b;
  logic                  bit_a, bit_b;
  logic [LOG_W-1:0]      la, lb;
  logic [63:0]           ln_prod;
  logic [46:0]           slope_prod;
  logic [DIVIDEND_W-1:0] dividend;
  logic [DIVISOR_W:0]    trial;
  logic                  q_bit;
  logic signed [15:0]    t_wide;

  // Position of the leading one of a nonzero code.
  function automatic logic [EXP_W-1:0] lead_pos(input logic [CODE_W-1:0] n);
    logic [EXP_W-1:0] p;
    p = '0;
    for (int i = 0; i < CODE_W; i++) begin
      if (n[i]) begin
        p = EXP_W'(i);
      end
    end
    return p;
  endfunction

  // Normalize the code to a Q30 mantissa in [1, 2).
  function automatic logic [MANT_W-1:0] mant_init(input logic [CODE_W-1:0] n,
                                                  input logic [EXP_W-1:0] k);
    logic [CODE_W+30-1:0] ext;
    ext = {n, 30'b0} >> k;
    return ext[MANT_W-1:0];
  endfunction

  always_comb begin
    code_b  = CODE_FULL - code_i;
    ka_d    = lead_pos(code_i);
    kb_d    = lead_pos(code_b);
    ma_init = mant_init(code_i, ka_d);
    mb_init = mant_init(code_b, kb_d);

    // One squaring step; a product of two or more renormalizes and yields a one bit.
    sq_a  = ma_q * ma_q;
    sq_b  = mb_q * mb_q;
    bit_a = sq_a[2*MANT_W-1];
    bit_b = sq_b[2*MANT_W-1];
    ma_d  = bit_a ? sq_a[2*MANT_W-1:31] : sq_a[2*MANT_W-2:30];
    mb_d  = bit_b ? sq_b[2*MANT_W-1:31] : sq_b[2*MANT_W-2:30];

    la = {ka_q, fa_q};
    lb = {kb_q, fb_q};

    ln_prod    = 64'(mag_q) * 64'(LN2_Q32);
    slope_prod = 47'(lnmag_q) * 47'(DQ_SLOPE);

    dividend = TEN_N + DIVIDEND_W'(dq_q);

    trial = {rem_q, low_q[QUO_W-1]};
    q_bit = trial >= {1'b0, div_q};

    // The divider works on 10N + Dq, which moves the quotient up by Q_OFFSET.
    t_wide = $signed({2'b00, quo_q}) - Q_OFFSET;
    if (t_wide < 16'(T_MIN)) begin
      temp_o = T_MIN;
    end else if (t_wide > 16'(T_MAX)) begin
      temp_o = T_MAX;
    end else begin
      temp_o = TEMP_W'(t_wide);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.conv_start) begin
      ma_q <= ma_init;
      mb_q <= mb_init;
      ka_q <= ka_d;
      kb_q <= kb_d;
      fa_q <= '0;
      fb_q <= '0;
    end
    if (cmd_i.log_step) begin
      ma_q <= ma_d;
      mb_q <= mb_d;
      fa_q <= {fa_q[FRAC_W-2:0], bit_a};
      fb_q <= {fb_q[FRAC_W-2:0], bit_b};
    end
    if (cmd_i.mag_step) begin
      neg_q <= la < lb;
      mag_q <= (la < lb) ? (lb - la) : (la - lb);
    end
    if (cmd_i.ln_step) begin
      lnmag_q <= ln_prod[63:32];
    end
    if (cmd_i.dq_step) begin
      dq_q <= neg_q ? (DQ_BASE - DQ_W'(slope_prod)) : (DQ_BASE + DQ_W'(slope_prod));
    end
    if (cmd_i.div_load) begin
      div_q <= ({4'b0, dq_q} << 3) + ({4'b0, dq_q} << 1);
      rem_q <= DIVISOR_W'(dividend[DIVIDEND_W-1:QUO_W]);
      low_q <= dividend[QUO_W-1:0];
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= q_bit ? DIVISOR_W'(trial - {1'b0, div_q}) : DIVISOR_W'(trial);
      low_q <= {low_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], q_bit};
    end
  end

`ifndef NO_ASSERTIONS
  // Squaring keeps both mantissas normalized in [1, 2).
  a_mant_norm: assert property (@(posedge clk_i)
    $past(cmd_i.log_step) |-> (ma_q[MANT_W-1] && mb_q[MANT_W-1]))
    else $error("log2 mantissa left normalized range");

  // The partial remainder stays below the divisor, so the quotient fits.
  a_rem_bound: assert property (@(posedge clk_i)
    cmd_i.div_step |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");
`endif

endmodule

// ----- rtl/tsza_store.sv -----
// Channel and zone storage, fault classification, zone averaging and result register.
module tsza_store (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tsza_pkg::cmd_t                    cmd_i,
  output tsza_pkg::sts_t                    sts_o,
  input  logic                              req_i,
  input  logic [tsza_pkg::CH_W-1:0]         channel_i,
  input  logic [tsza_pkg::CODE_W-1:0]       adc_sample_i,
  input  logic [tsza_pkg::CODE_W-1:0]       low_limit_i,
  input  logic [tsza_pkg::CODE_W-1:0]       high_limit_i,
  input  logic signed [tsza_pkg::TEMP_W-1:0] conv_temp_i,
  output logic [tsza_pkg::CODE_W-1:0]       code_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              out_kind_o,
  output logic [tsza_pkg::CH_W-1:0]         out_index_o,
  output logic signed [tsza_pkg::TEMP_W-1:0] out_temp_o,
  output logic [tsza_pkg::FAULT_W-1:0]      out_fault_o,
  output logic                              out_last_o
);
  import tsza_pkg::*;

  logic                      req_q;
  logic [CH_W-1:0]           ch_q;
  logic [CODE_W-1:0]         code_q;
  logic signed [TEMP_W-1:0]  chan_temp_q [CHANNELS];
  logic [FAULT_W-1:0]        chan_fault_q [CHANNELS];
  logic signed [TEMP_W-1:0]  zone_temp_q [ZONES];
  logic signed [TEMP_W-1:0]  zone_next [ZONES];

  logic                      out_valid_q;
  logic                      out_kind_q;
  logic [CH_W-1:0]           out_index_q;
  logic signed [TEMP_W-1:0]  out_temp_q;
  logic [FAULT_W-1:0]        out_fault_q;
  logic                      out_last_q;

  logic [FAULT_W-1:0]        fault_cls;
  logic signed [TEMP_W-1:0]  chan_res;
  logic [CH_IDX_W-1:0]       ch_sel;

  always_comb begin
    // The low limit is checked first and wins when the limits overlap.
    if (code_q <= low_limit_i) begin
      fault_cls = FAULT_LOW;
      chan_res  = T_LOW_FAULT;
    end else if (code_q >= high_limit_i) begin
      fault_cls = FAULT_HIGH;
      chan_res  = T_HIGH_FAULT;
    end else begin
      fault_cls = FAULT_NONE;
      chan_res  = conv_temp_i;
    end
    ch_sel = CH_IDX_W'(ch_q);

    sts_o.is_end     = req_q == REQ_END;
    sts_o.ch_present = 32'(ch_q) < CHANNELS;
    sts_o.fault_hit  = fault_cls != FAULT_NONE;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign code_o = code_q;

  // Each zone looks at its own fixed even/odd channel pair.
  for (genvar z = 0; z < ZONES; z++) begin : g_zone
    if (2 * z + 1 < CHANNELS) begin : g_pair
      logic v_even, v_odd;
      logic signed [TEMP_W:0] sum;
      assign v_even = chan_fault_q[2*z] == FAULT_NONE;
      assign v_odd  = chan_fault_q[2*z+1] == FAULT_NONE;
      assign sum    = (TEMP_W+1)'(chan_temp_q[2*z]) + (TEMP_W+1)'(chan_temp_q[2*z+1]);
      assign zone_next[z] = (v_even && v_odd) ? TEMP_W'(sum >>> 1) :
                            v_even ? chan_temp_q[2*z] :
                            v_odd  ? chan_temp_q[2*z+1] : zone_temp_q[z];
    end else if (2 * z < CHANNELS) begin : g_single
      assign zone_next[z] = (chan_fault_q[2*z] == FAULT_NONE) ? chan_temp_q[2*z]
                                                              : zone_temp_q[z];
    end else begin : g_none
      assign zone_next[z] = zone_temp_q[z];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_i;
      ch_q   <= channel_i;
      code_q <= adc_sample_i;
    end
    if (cmd_i.chan_wr) begin
      out_kind_q  <= KIND_CHAN;
      out_index_q <= ch_q;
      out_temp_q  <= chan_res;
      out_fault_q <= fault_cls;
      out_last_q  <= 1'b1;
    end else if (cmd_i.zone_wr) begin
      out_kind_q  <= KIND_ZONE;
      out_index_q <= CH_W'(cmd_i.zone_idx);
      out_temp_q  <= zone_next[cmd_i.zone_idx];
      out_fault_q <= FAULT_NONE;
      out_last_q  <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        chan_temp_q[i]  <= '0;
        chan_fault_q[i] <= FAULT_NONE;
      end
      for (int i = 0; i < ZONES; i++) begin
        zone_temp_q[i] <= ZONE_RST;
      end
    end else begin
      if (cmd_i.chan_wr || cmd_i.zone_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.chan_wr) begin
        chan_temp_q[ch_sel]  <= chan_res;
        chan_fault_q[ch_sel] <= fault_cls;
      end
      if (cmd_i.zone_wr) begin
        zone_temp_q[cmd_i.zone_idx] <= zone_next[cmd_i.zone_idx];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_index_o = out_index_q;
  assign out_temp_o  = out_temp_q;
  assign out_fault_o = out_fault_q;
  assign out_last_o  = out_last_q;

`ifndef NO_ASSERTIONS
  // A new result only appears after the controller asked for one.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.chan_wr || cmd_i.zone_wr))
    else $error("result appeared without a write command");

  // Zone results never carry a fault code.
  a_zone_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_ZONE) |-> (out_fault_q == FAULT_NONE))
    else $error("zone result with nonzero fault");
`endif

endmodule

// ----- rtl/tsza_ctrl.sv -----
// Sequencing state machine for sample conversion and zone emission.
module tsza_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tsza_pkg::sts_t sts_i,
  output tsza_pkg::cmd_t cmd_o
);
  import tsza_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             zone_last;

  assign zone_last = cnt_q == CNT_W'(ZONES - 1);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o        = '0;
    cmd_o.zone_idx = cnt_q[ZONE_W-1:0];
    cmd_o.last   = zone_last;
    in_ready_o   = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_d = '0;
        if (sts_i.is_end) begin
          state_d = S_ZONE;
        end else if (!sts_i.ch_present) begin
          state_d = S_IDLE;
        end else if (sts_i.fault_hit) begin
          state_d = S_CHOUT;
        end else begin
          cmd_o.conv_start = 1'b1;
          state_d          = S_LOG;
        end
      end
      S_LOG: begin
        cmd_o.log_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(LOG_STEPS - 1)) begin
          state_d = S_MAG;
        end
      end
      S_MAG: begin
        cmd_o.mag_step = 1'b1;
        state_d        = S_LN;
      end
      S_LN: begin
        cmd_o.ln_step = 1'b1;
        state_d       = S_DQ;
      end
      S_DQ: begin
        cmd_o.dq_step = 1'b1;
        state_d       = S_DIVLD;
      end
      S_DIVLD: begin
        cmd_o.div_load = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_CHOUT;
        end
      end
      S_CHOUT: begin
        if (sts_i.out_free) begin
          cmd_o.chan_wr = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_ZONE: begin
        if (sts_i.out_free) begin
          cmd_o.zone_wr = 1'b1;
          cnt_d         = cnt_q + 1'b1;
          if (zone_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  // Step counters never run past their loop length.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_LOG) |-> (cnt_q < CNT_W'(LOG_STEPS))) and
    ((state_q == S_DIV) |-> (cnt_q < CNT_W'(DIV_STEPS))) and
    ((state_q == S_ZONE) |-> (cnt_q < CNT_W'(ZONES))))
    else $error("step counter out of range");
`endif

endmodule

// ----- rtl/thermistor_scan_zone_averager_unit.sv -----
// Top level of the thermistor scan zone averager.
//
// This block turns raw 12-bit thermistor divider codes into temperatures in
// 1/16 degree Celsius and keeps per-channel and per-zone readings. A sample
// request (tuser 0) stores and reports the temperature and fault code of its
// channel; a code at or below the low fault limit reports -127 C with fault 1,
// a code at or above the high fault limit reports 200 C with fault 2, and any
// other code goes through the NTC Beta equation (10 kOhm at 25 C, B = 3950),
// rounded to the nearest 1/16 C and clamped to -127..200 C. An end-of-scan
// request (tuser 1) emits one result per zone, zone 0 first, with tlast on the
// final one; each zone averages its valid even/odd channel pair (rounding
// toward minus infinity), takes the single valid one, or repeats its previous
// value. Zones start at 25 C after reset. The block handles one request at a
// time. A sample that needs the Beta conversion occupies it from acceptance
// until it takes the next request, through the log2 squaring loop, shared
// by both codes, and then the restoring divider. A faulted sample and an
// end-of-scan request also occupy it, and every request can be held
// longer while the result register waits on m_axis_tready. A request
// is still accepted while the last result waits in the output register.
// Configuration writes are always accepted and must only be issued while the
// block is idle.
module thermistor_scan_zone_averager_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  // Sample and end-of-scan requests.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [2:0] channel, [14:3] adc_sample, [15] zero
  input  logic [tsza_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] req_type
  input  logic [tsza_pkg::REQ_W-1:0]          s_axis_tuser,

  // Channel readings and zone temperatures.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [2:0] index, [15:3] temperature, [17:16] fault, [23:18] zero
  output logic [tsza_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [0] kind
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast,

  // Register writes: index 0 low fault limit, index 1 high fault limit.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tsza_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tsza_pkg::CODE_W-1:0]         cfg_data_i
);
  import tsza_pkg::*;

  logic [CODE_W-1:0]        low_limit_q, high_limit_q;
  cmd_t                     cmd;
  sts_t                     sts;
  logic [CODE_W-1:0]        code;
  logic signed [TEMP_W-1:0] conv_temp;
  logic [CH_W-1:0]          out_index;
  logic signed [TEMP_W-1:0] out_temp;
  logic [FAULT_W-1:0]       out_fault;

  // Writes to indexes beyond the register list are accepted and dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_limit_q  <= LOW_LIMIT_RST;
      high_limit_q <= HIGH_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LOW_LIMIT:  low_limit_q  <= cfg_data_i;
        REG_HIGH_LIMIT: high_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tsza_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tsza_conv u_conv (
    .clk_i  (clk_i),
    .cmd_i  (cmd),
    .code_i (code),
    .temp_o (conv_temp)
  );

  tsza_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_i        (s_axis_tuser[0]),
    .channel_i    (s_axis_tdata[CH_W-1:0]),
    .adc_sample_i (s_axis_tdata[CH_W+CODE_W-1:CH_W]),
    .low_limit_i  (low_limit_q),
    .high_limit_i (high_limit_q),
    .conv_temp_i  (conv_temp),
    .code_o       (code),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_kind_o   (m_axis_tuser),
    .out_index_o  (out_index),
    .out_temp_o   (out_temp),
    .out_fault_o  (out_fault),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {(OUT_DATA_W - CH_W - TEMP_W - FAULT_W)'(0),
                         out_fault, out_temp, out_index};

endmodule
